### hdl/smclpf_pkg.sv
`timescale 1ns / 1ps

package smclpf_pkg;

    // Register file geometry
    localparam int unsigned APB_ADDR_W = 5;
    localparam int unsigned APB_DATA_W = 32;

    // Register reset values
    localparam logic [31:0] GAIN_K_RESET      = 32'd65536;
    localparam logic [31:0] LAMBDA_RESET      = 32'd65536;
    localparam logic [31:0] INV_PHI_RESET     = 32'd65536;
    localparam logic [31:0] INV_DT_RESET      = 32'd6553600;
    localparam logic [16:0] LPF_ALPHA_RESET   = 17'd13107;

    // Unity in Q16.16 / Q1.16
    localparam logic [16:0] ONE_Q16 = 17'd65536;

    // Depth of the queue between intake and datapath
    localparam int unsigned QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        REG_GAIN_K    = 3'd0,
        REG_LAMBDA    = 3'd1,
        REG_INV_PHI   = 3'd2,
        REG_INV_DT    = 3'd3,
        REG_LPF_ALPHA = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic signed [31:0] target_distance;
        logic signed [31:0] measured_distance;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] drive_value;
        logic signed [31:0] filtered_rate;
        logic signed [31:0] surface_value;
        logic signed [31:0] tracking_error;
    } out_item_t;

    typedef struct packed {
        logic [31:0] gain_k;
        logic [31:0] lambda_gain;
        logic [31:0] inv_phi;
        logic [31:0] inv_dt;
        logic [16:0] lpf_alpha;
    } cfg_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL_DIST,
        ST_POST_DIST,
        ST_ERR,
        ST_MUL_RATE,
        ST_POST_RATE,
        ST_MUL_RLPF,
        ST_POST_RLPF,
        ST_MUL_LAM,
        ST_POST_LAM,
        ST_SURF,
        ST_MUL_PHI,
        ST_POST_PHI,
        ST_TANH_IDX,
        ST_TANH_LUT,
        ST_MUL_DRIVE,
        ST_POST_DRIVE
    } back_state_t;

endpackage

### hdl/smclpf_regs.sv
`timescale 1ns / 1ps

module smclpf_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [smclpf_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [smclpf_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [smclpf_pkg::APB_DATA_W-1:0]  prdata,
    output logic                               pready,
    output smclpf_pkg::cfg_t                   cfg
);
    import smclpf_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t reg_idx;
    logic     wr_en;

    assign reg_idx = reg_idx_t'(paddr[4:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    // Decode a write; unknown indexes leave everything as is
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_GAIN_K:    cfg_next.gain_k      = pwdata;
                REG_LAMBDA:    cfg_next.lambda_gain = pwdata;
                REG_INV_PHI:   cfg_next.inv_phi     = pwdata;
                REG_INV_DT:    cfg_next.inv_dt      = pwdata;
                REG_LPF_ALPHA: cfg_next.lpf_alpha   = pwdata[16:0];
                default:       cfg_next             = cfg_reg;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (reg_idx)
            REG_GAIN_K:    prdata = cfg_reg.gain_k;
            REG_LAMBDA:    prdata = cfg_reg.lambda_gain;
            REG_INV_PHI:   prdata = cfg_reg.inv_phi;
            REG_INV_DT:    prdata = cfg_reg.inv_dt;
            REG_LPF_ALPHA: prdata = {15'd0, cfg_reg.lpf_alpha};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_k      <= GAIN_K_RESET;
            cfg_reg.lambda_gain <= LAMBDA_RESET;
            cfg_reg.inv_phi     <= INV_PHI_RESET;
            cfg_reg.inv_dt      <= INV_DT_RESET;
            cfg_reg.lpf_alpha   <= LPF_ALPHA_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### hdl/smclpf_front.sv
`timescale 1ns / 1ps

module smclpf_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  smclpf_pkg::in_item_t    in_data,
    output logic                    push_valid,
    input  logic                    push_ready,
    output smclpf_pkg::in_item_t    push_data
);
    import smclpf_pkg::*;

    logic     hold_valid_reg;
    logic     hold_valid_next;
    in_item_t hold_data_reg;
    in_item_t hold_data_next;

    // Take a new item whenever the holding register is empty or draining
    assign in_ready   = !hold_valid_reg || push_ready;
    assign push_valid = hold_valid_reg;
    assign push_data  = hold_data_reg;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        hold_data_next  = hold_data_reg;
        if (push_ready)
        begin
            hold_valid_next = 1'b0;
        end
        if (in_valid && in_ready)
        begin
            hold_valid_next = 1'b1;
            hold_data_next  = in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_data_reg <= hold_data_next;
    end

endmodule

### hdl/smclpf_queue.sv
`timescale 1ns / 1ps

module smclpf_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push_valid,
    output logic                    push_ready,
    input  smclpf_pkg::in_item_t    push_data,
    output logic                    pop_valid,
    input  logic                    pop_ready,
    output smclpf_pkg::in_item_t    pop_data
);
    import smclpf_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    in_item_t         slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Advance pointers with wrap, track fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed item
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### hdl/smclpf_back.sv
`timescale 1ns / 1ps

module smclpf_back #(
    parameter int unsigned TANH_ENTRIES = 256
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  smclpf_pkg::cfg_t        cfg,
    input  logic                    pop_valid,
    output logic                    pop_ready,
    input  smclpf_pkg::in_item_t    pop_data,
    output logic                    out_valid,
    input  logic                    out_ready,
    output smclpf_pkg::out_item_t   out_data
);
    import smclpf_pkg::*;

    localparam int unsigned IDX_W  = $clog2(TANH_ENTRIES);
    localparam int unsigned NUM_W  = $clog2(TANH_ENTRIES + 1);
    localparam int unsigned PROD_W = 18 + NUM_W;
    localparam logic [PROD_W-1:0] ENTRIES_EXT = PROD_W'(TANH_ENTRIES);
    localparam logic [63:0] Q30_ONE = 64'd1 << 30;

    // Table step h = 4/N in Q30 and its odd powers
    localparam logic [63:0] TANH_H  = (64'd4 << 30) / 64'(TANH_ENTRIES);
    localparam logic [63:0] TANH_H2 = (TANH_H * TANH_H) >> 30;
    localparam logic [63:0] TANH_H3 = (TANH_H2 * TANH_H) >> 30;
    localparam logic [63:0] TANH_H5 = (TANH_H3 * TANH_H2) >> 30;
    localparam logic [63:0] TANH_H7 = (TANH_H5 * TANH_H2) >> 30;
    localparam logic [63:0] TANH_H9 = (TANH_H7 * TANH_H2) >> 30;

    // tanh(h) from its series
    localparam logic [63:0] TANH_STEP = TANH_H + (64'd2 * TANH_H5) / 64'd15
                                        + (64'd62 * TANH_H9) / 64'd2835
                                        - TANH_H3 / 64'd3 - (64'd17 * TANH_H7) / 64'd315;

    // Unsigned quotient by long division, used only while building the table
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den})
            begin
                rem  = rem - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Entry k = tanh(4k/N) in Q16.16, built in Q30 by the addition theorem
    function automatic logic [TANH_ENTRIES*17-1:0] tanh_table();
        logic [TANH_ENTRIES*17-1:0] tab;
        logic [63:0]                t;
        tab = '0;
        t   = 64'd0;
        for (int k = 0; k < TANH_ENTRIES; k++)
        begin
            tab[k*17 +: 17] = 17'((t + 64'd8192) >> 14);
            t = udiv64((t + TANH_STEP) << 30, Q30_ONE + ((t * TANH_STEP) >> 30));
        end
        return tab;
    endfunction

    localparam logic [TANH_ENTRIES*17-1:0] TANH_TABLE = tanh_table();

    function automatic logic signed [65:0] sx66(input logic signed [31:0] v);
        return {{34{v[31]}}, v};
    endfunction

    function automatic logic signed [32:0] sx33(input logic signed [31:0] v);
        return {v[31], v};
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v[65:31] == '0 || v[65:31] == '1)
        begin
            r = v[31:0];
        end
        else if (v[65])
        begin
            r = {1'b1, 31'd0};
        end
        else
        begin
            r = {1'b0, {31{1'b1}}};
        end
        return r;
    endfunction

    // Product over 65536, ties away from zero
    function automatic logic signed [31:0] round_q16(input logic signed [65:0] p);
        logic signed [65:0] r;
        r = p + (p[65] ? 66'sd32767 : 66'sd32768);
        return sat32(r >>> 16);
    endfunction

    // Filter update: floor((alpha*(x - y) + 65536*y + 32768) / 65536)
    function automatic logic signed [31:0] lpf_post(input logic signed [65:0] p,
                                                    input logic signed [31:0] prev);
        logic signed [65:0] acc;
        acc = p + {{18{prev[31]}}, prev, 16'd0} + 66'sd32768;
        return sat32(acc >>> 16);
    endfunction

    // tanh table as constant logic
    logic [16:0] tanh_rom [TANH_ENTRIES];
    for (genvar g = 0; g < TANH_ENTRIES; g++)
    begin : g_tanh
        assign tanh_rom[g] = TANH_TABLE[g*17 +: 17];
    end

    back_state_t        state_reg;
    back_state_t        state_next;
    logic signed [31:0] df_reg;
    logic signed [31:0] df_next;
    logic signed [31:0] rf_reg;
    logic signed [31:0] rf_next;
    logic signed [31:0] perr_reg;
    logic signed [31:0] perr_next;
    logic signed [31:0] err_reg;
    logic signed [31:0] err_next;
    logic signed [31:0] tgt_reg;
    logic signed [31:0] tgt_next;
    logic signed [31:0] lm_reg;
    logic signed [31:0] lm_next;
    logic signed [31:0] s_reg;
    logic signed [31:0] s_next;
    logic signed [31:0] x_reg;
    logic signed [31:0] x_next;
    logic [IDX_W-1:0]   tidx_reg;
    logic [IDX_W-1:0]   tidx_next;
    logic               tbig_reg;
    logic               tbig_next;
    logic               tneg_reg;
    logic               tneg_next;
    logic signed [32:0] op_a_reg;
    logic signed [32:0] op_a_next;
    logic [31:0]        op_b_reg;
    logic [31:0]        op_b_next;
    logic signed [65:0] p_reg;
    logic signed [65:0] p_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    out_item_t          out_data_reg;
    out_item_t          out_data_next;

    logic [16:0]        alpha_eff;
    logic [31:0]        alpha_op;
    logic signed [31:0] err_new;
    logic signed [31:0] round_p;
    logic signed [31:0] surf_new;
    logic signed [32:0] x_mag;
    logic [PROD_W-1:0]  tanh_prod;
    logic [16:0]        tanh_val;

    assign alpha_eff = (cfg.lpf_alpha > ONE_Q16) ? ONE_Q16 : cfg.lpf_alpha;
    assign alpha_op  = {15'd0, alpha_eff};
    assign err_new   = sat32(sx66(df_reg) - sx66(tgt_reg));
    assign round_p   = round_q16(p_reg);
    assign surf_new  = sat32(sx66(rf_reg) + sx66(lm_reg));
    assign x_mag     = x_reg[31] ? -sx33(x_reg) : sx33(x_reg);
    assign tanh_prod = PROD_W'(x_mag[17:0]) * ENTRIES_EXT;
    assign tanh_val  = tbig_reg ? ONE_Q16 : tanh_rom[tidx_reg];

    // Shared multiplier: signed operand times unsigned Q16.16 register
    assign p_next = 66'(op_a_reg) * 66'(signed'({1'b0, op_b_reg}));

    assign pop_ready = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Sequencer: one multiply and one post step per stage of the chain
    always_comb
    begin
        state_next     = state_reg;
        df_next        = df_reg;
        rf_next        = rf_reg;
        perr_next      = perr_reg;
        err_next       = err_reg;
        tgt_next       = tgt_reg;
        lm_next        = lm_reg;
        s_next         = s_reg;
        x_next         = x_reg;
        tidx_next      = tidx_reg;
        tbig_next      = tbig_reg;
        tneg_next      = tneg_reg;
        op_a_next      = op_a_reg;
        op_b_next      = op_b_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        // Drop the result once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid)
                begin
                    tgt_next   = pop_data.target_distance;
                    op_a_next  = sx33(pop_data.measured_distance) - sx33(df_reg);
                    op_b_next  = alpha_op;
                    state_next = ST_MUL_DIST;
                end
            end
            ST_MUL_DIST:
            begin
                state_next = ST_POST_DIST;
            end
            ST_POST_DIST:
            begin
                df_next    = lpf_post(p_reg, df_reg);
                state_next = ST_ERR;
            end
            ST_ERR:
            begin
                err_next   = err_new;
                perr_next  = err_new;
                op_a_next  = sx33(err_new) - sx33(perr_reg);
                op_b_next  = cfg.inv_dt;
                state_next = ST_MUL_RATE;
            end
            ST_MUL_RATE:
            begin
                state_next = ST_POST_RATE;
            end
            ST_POST_RATE:
            begin
                op_a_next  = sx33(round_p) - sx33(rf_reg);
                op_b_next  = alpha_op;
                state_next = ST_MUL_RLPF;
            end
            ST_MUL_RLPF:
            begin
                state_next = ST_POST_RLPF;
            end
            ST_POST_RLPF:
            begin
                rf_next    = lpf_post(p_reg, rf_reg);
                op_a_next  = sx33(err_reg);
                op_b_next  = cfg.lambda_gain;
                state_next = ST_MUL_LAM;
            end
            ST_MUL_LAM:
            begin
                state_next = ST_POST_LAM;
            end
            ST_POST_LAM:
            begin
                lm_next    = round_p;
                state_next = ST_SURF;
            end
            ST_SURF:
            begin
                s_next     = surf_new;
                op_a_next  = sx33(surf_new);
                op_b_next  = cfg.inv_phi;
                state_next = ST_MUL_PHI;
            end
            ST_MUL_PHI:
            begin
                state_next = ST_POST_PHI;
            end
            ST_POST_PHI:
            begin
                x_next     = round_p;
                state_next = ST_TANH_IDX;
            end
            ST_TANH_IDX:
            begin
                tbig_next  = (x_mag[32:18] != '0);
                tidx_next  = tanh_prod[18 +: IDX_W];
                tneg_next  = x_reg[31];
                state_next = ST_TANH_LUT;
            end
            ST_TANH_LUT:
            begin
                // Drive takes the opposite sign of the surface
                op_a_next  = tneg_reg ? signed'({16'd0, tanh_val})
                                      : -signed'({16'd0, tanh_val});
                op_b_next  = cfg.gain_k;
                state_next = ST_MUL_DRIVE;
            end
            ST_MUL_DRIVE:
            begin
                state_next = ST_POST_DRIVE;
            end
            ST_POST_DRIVE:
            begin
                // Hold here while the output register is still occupied
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next               = 1'b1;
                    out_data_next.drive_value    = round_p;
                    out_data_next.filtered_rate  = rf_reg;
                    out_data_next.surface_value  = s_reg;
                    out_data_next.tracking_error = err_reg;
                    state_next                   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            df_reg        <= '0;
            rf_reg        <= '0;
            perr_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            df_reg        <= df_next;
            rf_reg        <= rf_next;
            perr_reg      <= perr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg      <= err_next;
        tgt_reg      <= tgt_next;
        lm_reg       <= lm_next;
        s_reg        <= s_next;
        x_reg        <= x_next;
        tidx_reg     <= tidx_next;
        tbig_reg     <= tbig_next;
        tneg_reg     <= tneg_next;
        op_a_reg     <= op_a_next;
        op_b_reg     <= op_b_next;
        p_reg        <= p_next;
        out_data_reg <= out_data_next;
    end

endmodule

### hdl/sliding_mode_controller_lpf_top.sv
`timescale 1ns / 1ps
// Channel   Signals                              Moves
// in        in_valid / in_ready / in_data        reference and raw distance, one item
// out       out_valid / out_ready / out_data     drive, rate, surface, error, one item
// cfg       psel penable pwrite paddr pwdata     register writes and reads, pready tied high
//
// Each item runs through the datapath sequencer: six passes through the one
// shared 33x33 multiplier, each followed by a rounding/filter step, plus the error,
// surface, tanh index and table steps. The next item starts the cycle after a result is loaded.
// Reset zeroes the filter and previous-error state and loads register defaults.
// A waiting result in the output register holds the sequencer in its last step;
// the intake register and queue still take up to three more items meanwhile.

module sliding_mode_controller_lpf_top #(
    parameter int unsigned TANH_ENTRIES = 256
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  smclpf_pkg::in_item_t               in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output smclpf_pkg::out_item_t              out_data,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [smclpf_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [smclpf_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [smclpf_pkg::APB_DATA_W-1:0]  prdata,
    output logic                               pready
);
    import smclpf_pkg::*;

    cfg_t     cfg;
    logic     push_valid;
    logic     push_ready;
    in_item_t push_data;
    logic     pop_valid;
    logic     pop_ready;
    in_item_t pop_data;

    smclpf_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    smclpf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    smclpf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    smclpf_back #(
        .TANH_ENTRIES (TANH_ENTRIES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

### hdl/smclpf_checker.sv
`timescale 1ns / 1ps

module smclpf_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_ready,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  smclpf_pkg::out_item_t              out_data,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [smclpf_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [smclpf_pkg::APB_DATA_W-1:0]  pwdata,
    input  logic [smclpf_pkg::APB_DATA_W-1:0]  prdata,
    input  logic                               pready
);
    import smclpf_pkg::*;

    logic [2:0] inflight_reg;
    logic [2:0] inflight_next;
    logic       in_acc;
    logic       out_acc;
    logic       wr_acc;
    logic       rd_known;

    assign in_acc   = in_valid && in_ready;
    assign out_acc  = out_valid && out_ready;
    assign wr_acc   = psel && penable && pwrite && pready;
    assign rd_known = (paddr[4:2] == REG_GAIN_K) || (paddr[4:2] == REG_LAMBDA)
                   || (paddr[4:2] == REG_INV_PHI) || (paddr[4:2] == REG_INV_DT)
                   || (paddr[4:2] == REG_LPF_ALPHA);

    // Count items accepted but not yet delivered
    always_comb
    begin
        inflight_next = inflight_reg + {2'd0, in_acc} - {2'd0, out_acc};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // No result without an item inside
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> inflight_reg != 3'd0)
        else $error("result with no item in flight");

    // Intake, queue, datapath and output register bound the items inside
    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= 3'd5)
        else $error("more items inside than storage allows");

    // An empty block takes an item
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg == 3'd0 |-> in_ready)
        else $error("empty block refuses an item");

    // A written register reads back in the next cycle
    a_readback: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) && $past(wr_acc) && psel && !pwrite && rd_known
        && paddr == $past(paddr)
        |-> prdata == (($past(paddr[4:2]) == REG_LPF_ALPHA)
                       ? ($past(pwdata) & 32'h0001_FFFF) : $past(pwdata)))
        else $error("register read back differs from write");

endmodule

bind sliding_mode_controller_lpf_top smclpf_checker u_checker (.*);
